### src/least_squares_line_fit_macros.svh
// Assertion macros shared by the line fit block.
`ifndef LEAST_SQUARES_LINE_FIT_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define LSLF_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("line fit check failed");

// Next-cycle implication, checked out of reset only.
`define LSLF_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("line fit check failed");

`endif

### src/lslf_pkg.sv
// Types, constants and helpers for the least-squares line fit block.
package lslf_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int MAX_POINTS  = 32768;
	localparam int OUT_W       = 48;
	localparam int CNT_W       = $clog2(MAX_POINTS + 1);
	localparam int SUM_W       = 2 * SAMPLE_BITS + CNT_W;
	localparam int PROD_W      = 2 * SUM_W;
	localparam int ACC_W       = PROD_W + 1;
	localparam int NUM_W       = PROD_W + FRAC_BITS;
	localparam int STEP_W      = $clog2(NUM_W + 2);

	typedef enum logic [1:0] {
		FIT_OK       = 2'd0,
		FIT_DEGEN    = 2'd1,
		FIT_OVERFLOW = 2'd2
	} fit_status_t;

	// Product schedule: first operand times second, into one of three sums.
	typedef enum logic [2:0] {
		OP_N_SXX   = 3'd0,
		OP_SX_SX   = 3'd1,
		OP_N_SXY   = 3'd2,
		OP_SX_SY   = 3'd3,
		OP_SY_SXX  = 3'd4,
		OP_SX_SXY  = 3'd5
	} prod_op_t;

	typedef struct packed {
		logic signed [15:0] x_sample;
		logic signed [15:0] y_sample;
		logic               last_point;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] slope;
		logic signed [47:0] intercept;
		fit_status_t        fit_status;
		logic [15:0]        point_count;
	} out_item_t;

	typedef struct packed {
		logic     acc_en;
		logic     clear_sums;
		logic     mul_load;
		logic     mul_step;
		logic     mul_acc;
		prod_op_t op;
		logic     div_load;
		logic     div_step;
		logic     div_store;
		logic     div_sel;
		logic     load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic den_zero;
	} dp_stat_t;

	function automatic logic [SUM_W-1:0] mag_sum(input logic signed [SUM_W-1:0] v);
		return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
	endfunction

	function automatic logic [PROD_W-1:0] mag_acc(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-1:0] m;
		m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
		return m[PROD_W-1:0];
	endfunction

endpackage

### src/lslf_datapath.sv
// Datapath: running sums, shift-add multiplier, restoring divider, result register.
module lslf_datapath import lslf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  ctl_cmd_t  cmd,
	output dp_stat_t  stat,
	output out_item_t out_data
);

	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sx_q, sy_q, sxy_q, sxx_q;
	logic                    ovf_q;

	logic [PROD_W-1:0]       ma_q, prod_q;
	logic [SUM_W-1:0]        mb_q;
	logic                    pneg_q;

	logic signed [ACC_W-1:0] den_q, ns_q, ni_q;

	logic [NUM_W-1:0]        dq_q;
	logic [PROD_W:0]         rem_q;
	logic [PROD_W-1:0]       dmag_q;
	logic                    qneg_q;
	logic signed [OUT_W-1:0] slope_q, icpt_q;

	out_item_t               out_q;

	logic signed [SAMPLE_BITS-1:0]   xs, ys;
	logic signed [2*SAMPLE_BITS-1:0] xy, xx;
	logic signed [SUM_W-1:0]         n_s, opa, opb;
	logic signed [ACC_W-1:0]         term, num_sel;
	logic                            neg_term;
	logic [PROD_W:0]                 rs;
	logic                            ge;
	logic                            big;
	logic signed [OUT_W-1:0]         qres;

	assign xs  = in_data.x_sample[SAMPLE_BITS-1:0];
	assign ys  = in_data.y_sample[SAMPLE_BITS-1:0];
	assign xy  = xs * ys;
	assign xx  = xs * xs;
	assign n_s = signed'(SUM_W'(cnt_q));

	always_comb begin
		unique case (cmd.op)
			OP_N_SXX: begin opa = n_s;  opb = sxx_q; end
			OP_SX_SX: begin opa = sx_q; opb = sx_q;  end
			OP_N_SXY: begin opa = n_s;  opb = sxy_q; end
			OP_SX_SY: begin opa = sx_q; opb = sy_q;  end
			OP_SY_SXX: begin opa = sy_q; opb = sxx_q; end
			OP_SX_SXY: begin opa = sx_q; opb = sxy_q; end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	// Odd steps of the schedule subtract their product.
	assign neg_term = pneg_q ^ cmd.op[0];
	assign term     = neg_term ? -signed'({1'b0, prod_q}) : signed'({1'b0, prod_q});
	assign num_sel  = cmd.div_sel ? ni_q : ns_q;

	assign rs  = {rem_q[PROD_W-1:0], dq_q[NUM_W-1]};
	assign ge  = rs >= {1'b0, dmag_q};
	assign big = |dq_q[NUM_W-1:OUT_W-1];
	always_comb begin
		if (big)
			qres = qneg_q ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
		else
			qres = qneg_q ? -signed'(dq_q[OUT_W-1:0]) : signed'(dq_q[OUT_W-1:0]);
	end

	// Sums and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
			sxx_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clear_sums) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
			sxx_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.acc_en) begin
			if (cnt_q < CNT_W'(MAX_POINTS)) begin
				cnt_q <= cnt_q + 1'b1;
				sx_q  <= sx_q + SUM_W'(xs);
				sy_q  <= sy_q + SUM_W'(ys);
				sxy_q <= sxy_q + SUM_W'(xy);
				sxx_q <= sxx_q + SUM_W'(xx);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Multiplier, fit sums and divider.
	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			ma_q   <= PROD_W'(mag_sum(opa));
			mb_q   <= mag_sum(opb);
			prod_q <= '0;
			pneg_q <= opa[SUM_W-1] ^ opb[SUM_W-1];
			if (cmd.op == OP_N_SXX) begin
				den_q <= '0;
				ns_q  <= '0;
				ni_q  <= '0;
			end
		end
		if (cmd.mul_step) begin
			if (mb_q[0])
				prod_q <= prod_q + ma_q;
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
		if (cmd.mul_acc) begin
			unique case (cmd.op)
				OP_N_SXX, OP_SX_SX:   den_q <= den_q + term;
				OP_N_SXY, OP_SX_SY:   ns_q  <= ns_q + term;
				OP_SY_SXX, OP_SX_SXY: ni_q  <= ni_q + term;
				default: ;
			endcase
		end
		if (cmd.div_load) begin
			dq_q   <= NUM_W'(mag_acc(num_sel)) << FRAC_BITS;
			dmag_q <= mag_acc(den_q);
			rem_q  <= '0;
			qneg_q <= num_sel[ACC_W-1] ^ den_q[ACC_W-1];
		end
		if (cmd.div_step) begin
			rem_q <= ge ? rs - {1'b0, dmag_q} : rs;
			dq_q  <= {dq_q[NUM_W-2:0], ge};
		end
		if (cmd.div_store) begin
			if (cmd.div_sel)
				icpt_q <= qres;
			else
				slope_q <= qres;
		end
		if (cmd.load_out) begin
			out_q.point_count <= 16'(cnt_q);
			if (den_q == '0) begin
				out_q.slope      <= '0;
				out_q.intercept  <= '0;
				out_q.fit_status <= FIT_DEGEN;
			end else begin
				out_q.slope      <= slope_q;
				out_q.intercept  <= icpt_q;
				out_q.fit_status <= ovf_q ? FIT_OVERFLOW : FIT_OK;
			end
		end
	end

	assign stat.den_zero = (den_q == '0);
	assign out_data      = out_q;

endmodule

### src/lslf_ctrl.sv
// Controller: sequences accumulation, six products, two skippable divisions and result.
module lslf_ctrl import lslf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_last,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_ACC  = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	prod_op_t          op_q;
	logic              sel_q;
	logic              out_valid_q;

	logic mul_end, div_end, div_skip;

	assign mul_end  = step_q == STEP_W'(SUM_W + 1);
	assign div_end  = step_q == STEP_W'(NUM_W + 1);
	assign div_skip = (step_q == '0) && stat.den_zero;

	always_comb begin
		cmd            = '0;
		cmd.op         = op_q;
		cmd.div_sel    = sel_q;
		cmd.acc_en     = (state_q == ST_ACC) && in_valid;
		cmd.mul_load   = (state_q == ST_MUL) && (step_q == '0);
		cmd.mul_step   = (state_q == ST_MUL) && (step_q != '0) && !mul_end;
		cmd.mul_acc    = (state_q == ST_MUL) && mul_end;
		cmd.div_load   = (state_q == ST_DIV) && (step_q == '0) && !stat.den_zero;
		cmd.div_step   = (state_q == ST_DIV) && (step_q != '0) && !div_end;
		cmd.div_store  = (state_q == ST_DIV) && div_end;
		cmd.load_out   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
		cmd.clear_sums = cmd.load_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			step_q      <= '0;
			op_q        <= OP_N_SXX;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_ACC: begin
					if (in_valid && in_last) begin
						state_q <= ST_MUL;
						step_q  <= '0;
						op_q    <= OP_N_SXX;
					end
				end
				ST_MUL: begin
					if (mul_end) begin
						step_q <= '0;
						if (op_q == OP_SX_SXY) begin
							state_q <= ST_DIV;
							sel_q   <= 1'b0;
						end else begin
							op_q <= prod_op_t'(op_q + 3'd1);
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_skip) begin
						state_q <= ST_DONE;
					end else if (div_end) begin
						step_q <= '0;
						sel_q  <= 1'b1;
						if (sel_q)
							state_q <= ST_DONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (cmd.load_out)
						state_q <= ST_ACC;
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	assign in_stall  = state_q != ST_ACC;
	assign out_valid = out_valid_q;

endmodule

### src/least_squares_line_fit.sv
// Top level of the least-squares straight-line fit block.
// Sample pairs are taken one per clock while the block accumulates, and are added into
// exact running sums. The pair marked last is added too, then input stalls while the
// fit is worked out: six products on a one-bit-per-cycle shift-add multiplier, then
// two restoring divisions, skipped when the denominator is zero, then the result is
// loaded. The result register lets the next set stream in while a finished fit waits
// to be taken; a second fit then holds at its end until the first has gone. Sums,
// count and overflow flag clear as the result is loaded.
`include "least_squares_line_fit_macros.svh"

module least_squares_line_fit import lslf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	lslf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_data.last_point),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	lslf_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

	// A result beat only appears after a fit has stalled the input.
	`LSLF_ASSERT_IMP(a_out_after_fit, clk, arst_n, $rose(out_valid), $past(in_stall))
	// An accepted last pair starts a fit.
	`LSLF_ASSERT_NXT(a_last_stalls, clk, arst_n, in_valid && !in_stall && in_data.last_point, in_stall)
	// A degenerate fit carries zero slope and intercept.
	`LSLF_ASSERT_IMP(a_degen_zero, clk, arst_n, out_valid && (out_data.fit_status == FIT_DEGEN), (out_data.slope == '0) && (out_data.intercept == '0))

endmodule

### sim/lslf_checker.sv
// Watches both channels of the line fit block, predicts each fit and compares.
module lslf_checker import lslf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_data,
	output int        fails,
	output int        fits_pending
);

	typedef logic signed [255:0] big_t;

	localparam big_t SAT_HI = (big_t'(1) <<< (OUT_W - 1)) - 1;
	localparam big_t SAT_LO = -(big_t'(1) <<< (OUT_W - 1));

	out_item_t fit_q[$];
	int        pairs_held;
	longint    acc_x, acc_y, acc_xy, acc_xx;
	logic      dropped;

	function automatic logic [47:0] clamp_out(input big_t q);
		if (q > SAT_HI) q = SAT_HI;
		else if (q < SAT_LO) q = SAT_LO;
		return q[47:0];
	endfunction

	// Work out the fit from the running sums, exactly.
	function automatic out_item_t fit_line();
		out_item_t r;
		big_t n, sx, sy, sxy, sxx, den, num_s, num_i;
		n   = big_t'(pairs_held);
		sx  = big_t'(acc_x);
		sy  = big_t'(acc_y);
		sxy = big_t'(acc_xy);
		sxx = big_t'(acc_xx);
		den = n * sxx - sx * sx;
		r.point_count = 16'(pairs_held);
		if (den == 0) begin
			r.slope      = '0;
			r.intercept  = '0;
			r.fit_status = FIT_DEGEN;
		end else begin
			num_s = (n * sxy - sx * sy) <<< FRAC_BITS;
			num_i = (sy * sxx - sx * sxy) <<< FRAC_BITS;
			r.slope      = clamp_out(num_s / den);
			r.intercept  = clamp_out(num_i / den);
			r.fit_status = dropped ? FIT_OVERFLOW : FIT_OK;
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		longint    xs, ys;
		if (!arst_n) begin
			fit_q.delete();
			pairs_held = 0;
			acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0;
			dropped = 1'b0;
			fails = 0;
		end else begin
			if (in_valid && !in_stall) begin
				xs = longint'(in_data.x_sample);
				ys = longint'(in_data.y_sample);
				if (pairs_held < MAX_POINTS) begin
					acc_x  += xs;
					acc_y  += ys;
					acc_xy += xs * ys;
					acc_xx += xs * xs;
					pairs_held++;
				end else begin
					dropped = 1'b1;
				end
				if (in_data.last_point) begin
					fit_q.push_back(fit_line());
					pairs_held = 0;
					acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0;
					dropped = 1'b0;
				end
			end
			if (out_valid && !out_stall) begin
				if (fit_q.size() == 0) begin
					report("unexpected fit", 64'(out_data.slope), 64'd0);
				end else begin
					want = fit_q.pop_front();
					if (out_data.slope !== want.slope)
						report("slope", 64'(out_data.slope), 64'(want.slope));
					if (out_data.intercept !== want.intercept)
						report("intercept", 64'(out_data.intercept), 64'(want.intercept));
					if (out_data.fit_status !== want.fit_status)
						report("fit_status", 64'(out_data.fit_status), 64'(want.fit_status));
					if (out_data.point_count !== want.point_count)
						report("point_count", 64'(out_data.point_count), 64'(want.point_count));
				end
			end
		end
		fits_pending = fit_q.size();
	end

endmodule

### sim/tb_top.sv
// Stimulus and verdict for the least-squares line fit block.
module tb_top import lslf_pkg::*; ();

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	int fails;
	int fits_pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	int pairs_sent = 0;

	always #10 clk = ~clk;

	least_squares_line_fit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	lslf_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fails(fails), .fits_pending(fits_pending)
	);

	// Receiver: random stall, or a long hold-off when one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				hold_len--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic send_pair(input logic [15:0] x, input logic [15:0] y, input logic last);
		logic stalled;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data  <= '{x_sample: x, y_sample: y, last_point: last};
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		pairs_sent++;
	endtask

	// Let the checker see the last accepted beat before polling its count.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (fits_pending != 0) @(posedge clk);
	endtask

	// One data set of random content; some sets share one x to force a degenerate fit.
	task automatic send_set(input int len);
		logic [15:0] x0;
		logic        flat;
		x0   = 16'($urandom);
		flat = ($urandom_range(9) == 0);
		for (int i = 0; i < len; i++)
			send_pair(flat ? x0 : 16'($urandom), 16'($urandom), i == len - 1);
	endtask

	task automatic random_phase(input int idle_pct, input int stall_pct, input int items);
		int goal;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		goal = pairs_sent + items;
		while (pairs_sent < goal)
			send_set(($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12));
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one lone point, no spread in x, sample extremes, steep lines.
		send_pair(16'sd5, 16'sd7, 1'b1);
		send_pair(16'sd3, 16'sd1, 1'b0);
		send_pair(16'sd3, -16'sd9, 1'b1);
		send_pair(-16'sd32768, -16'sd32768, 1'b0);
		send_pair(16'sd32767, 16'sd32767, 1'b1);
		send_pair(16'sd32767, -16'sd32768, 1'b0);
		send_pair(16'sd32766, 16'sd32767, 1'b1);
		send_pair(16'sd32766, -16'sd32768, 1'b0);
		send_pair(16'sd32767, 16'sd32767, 1'b1);
		send_pair(-16'sd32768, 16'sd32767, 1'b0);
		send_pair(-16'sd32767, -16'sd32768, 1'b0);
		send_pair(16'sd0, 16'sd0, 1'b1);
		send_pair(16'sd1, 16'sd2, 1'b0);
		send_pair(16'sd2, 16'sd4, 1'b0);
		send_pair(16'sd3, 16'sd7, 1'b1);
		send_pair(16'hAAAA, 16'h5555, 1'b0);
		send_pair(16'h5555, 16'hAAAA, 1'b1);
		drain();

		// Hold the output off long enough that the block backs up onto its input.
		hold_len = 3000;
		random_phase(0, 0, 120);
		random_phase(0, 0, 200);
		random_phase(85, 0, 250);
		random_phase(0, 85, 250);
		random_phase(34, 34, 250);
		random_phase(0, 0, 230);

		repeat (1000) @(posedge clk);
		if (fails == 0 && fits_pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#60000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
